>>> sv/pcq_pkg.sv
package pcq_pkg;

  localparam int ChanW      = 8;
  localparam int QuantShift = 3;
  localparam int LevelW     = ChanW - QuantShift;
  localparam int TableAw    = 3 * LevelW;
  localparam int TableDepth = 1 << TableAw;
  localparam int DistW      = 10;
  localparam int CountW     = 9;
  localparam int IndexW     = 8;

  localparam logic [DistW-1:0]  DistOnes   = '1;
  localparam logic [ChanW-1:0]  AlphaLimit = 8'd32;
  localparam logic [CountW-1:0] CountReset = 9'd256;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_BUILD = 2'd1,
    KIND_RGB   = 2'd2,
    KIND_ARGB  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_PALETTE_COUNT     = 2'd0,
    CFG_TRANSPARENT_INDEX = 2'd1,
    CFG_SUBSTITUTE_INDEX  = 2'd2,
    CFG_UNUSED            = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN,
    ST_WRITE,
    ST_DONE,
    ST_CONV
  } state_e;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       entry_number;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
  } in_item_t;

  typedef struct packed {
    logic [IndexW-1:0] color_index;
    logic              build_done;
  } out_item_t;

endpackage

>>> sv/pcq_in_if.sv
interface pcq_in_if;
  import pcq_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/pcq_out_if.sv
interface pcq_out_if;
  import pcq_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/palette_color_quantizer.sv
// Palette color quantizer. Load items write one palette entry each. A build item
// walks all 32768 5-bit-per-channel colors and, for each, scans palette entries 0 to n-1
// (n = palette_count, capped at PALETTE_DEPTH) through one palette read port and one
// shared L1 distance and compare unit, one entry per cycle; each color then passes a drain
// state and a table write state, and after the last color the build offers a completion
// result. A convert item reads the lookup table into a read register and, once the output
// is free, loads its result into the output register. The block takes one item at a time;
// a result waiting in the output register does not block acceptance of the next item.
module palette_color_quantizer
  import pcq_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CountW-1:0] cfg_data_i,
  pcq_in_if.sink            in_i,
  pcq_out_if.source         out_o
);

  localparam int PalAw = $clog2(PALETTE_DEPTH);
  localparam logic [CountW-1:0] PalDepthW = CountW'(PALETTE_DEPTH);

  logic [3*ChanW-1:0] pal_mem [PALETTE_DEPTH];
  logic [IndexW-1:0]  tbl_mem [TableDepth];

  logic [CountW-1:0] count_q;
  logic [IndexW-1:0] transp_q, subst_q;

  state_e state_q, state_d;

  logic [CountW-1:0]  issue_q;
  logic [TableAw-1:0] color_q;
  logic               rd_valid_q;
  logic [PalAw-1:0]   rd_entry_q;
  logic [3*ChanW-1:0] pal_rdata_q;
  logic [DistW-1:0]   best_dist_q;
  logic [IndexW-1:0]  best_entry_q;

  logic [IndexW-1:0] tbl_rdata_q;
  logic              low_alpha_q;

  logic      out_valid_q;
  out_item_t out_data_q;

  logic [CountW-1:0] n_entries;
  logic              issue_more, out_free, accept;
  logic              pal_rd_en, tbl_we, out_load;
  out_item_t         out_next;

  logic [TableAw-1:0] pix_addr;
  logic [ChanW-1:0]   exp_r, exp_g, exp_b;
  logic [ChanW-1:0]   diff_r, diff_g, diff_b;
  logic [DistW-1:0]   sum_dist;

  assign n_entries  = (count_q > PalDepthW) ? PalDepthW : count_q;
  assign issue_more = issue_q < n_entries;
  assign out_free   = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign pix_addr = {in_i.data.blue[ChanW-1 -: LevelW], in_i.data.green[ChanW-1 -: LevelW],
                     in_i.data.red[ChanW-1 -: LevelW]};

  // color under search, expanded back to 8 bits per channel
  assign exp_r = {color_q[LevelW-1:0], {QuantShift{1'b0}}};
  assign exp_g = {color_q[2*LevelW-1:LevelW], {QuantShift{1'b0}}};
  assign exp_b = {color_q[3*LevelW-1:2*LevelW], {QuantShift{1'b0}}};

  // shared distance unit
  always_comb begin
    logic [ChanW-1:0] pr, pg, pb;
    pr = pal_rdata_q[ChanW-1:0];
    pg = pal_rdata_q[2*ChanW-1:ChanW];
    pb = pal_rdata_q[3*ChanW-1:2*ChanW];
    diff_r = (pr > exp_r) ? pr - exp_r : exp_r - pr;
    diff_g = (pg > exp_g) ? pg - exp_g : exp_g - pg;
    diff_b = (pb > exp_b) ? pb - exp_b : exp_b - pb;
    sum_dist = DistW'(diff_r) + DistW'(diff_g) + DistW'(diff_b);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_i.data.kind)
            KIND_LOAD:  state_d = ST_IDLE;
            KIND_BUILD: state_d = ST_SEARCH;
            default:    state_d = ST_CONV;
          endcase
        end
      end
      ST_SEARCH: if (!issue_more) state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_WRITE;
      ST_WRITE:  state_d = (&color_q) ? ST_DONE : ST_SEARCH;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      ST_CONV:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_i.ready = 1'b0;
    pal_rd_en  = 1'b0;
    tbl_we     = 1'b0;
    out_load   = 1'b0;
    out_next   = '0;
    case (state_q)
      ST_IDLE:   in_i.ready = 1'b1;
      ST_SEARCH: pal_rd_en = issue_more;
      ST_DRAIN:  ;
      ST_WRITE:  tbl_we = 1'b1;
      ST_DONE: begin
        out_load = out_free;
        out_next.build_done = 1'b1;
      end
      ST_CONV: begin
        out_load = out_free;
        if (low_alpha_q) out_next.color_index = transp_q;
        else if (tbl_rdata_q == transp_q) out_next.color_index = subst_q;
        else out_next.color_index = tbl_rdata_q;
      end
      default: ;
    endcase
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= CountReset;
      transp_q <= '0;
      subst_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PALETTE_COUNT:     count_q  <= cfg_data_i;
        CFG_TRANSPARENT_INDEX: transp_q <= cfg_data_i[IndexW-1:0];
        CFG_SUBSTITUTE_INDEX:  subst_q  <= cfg_data_i[IndexW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      issue_q      <= '0;
      color_q      <= '0;
      rd_valid_q   <= 1'b0;
      best_dist_q  <= DistOnes;
      best_entry_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= pal_rd_en;
      if (pal_rd_en) issue_q <= issue_q + 1'b1;
      if (tbl_we) begin
        issue_q      <= '0;
        color_q      <= color_q + 1'b1;
        best_dist_q  <= DistOnes;
        best_entry_q <= '0;
      end else if (rd_valid_q && sum_dist < best_dist_q) begin
        // strict compare keeps the lowest index on ties
        best_dist_q  <= sum_dist;
        best_entry_q <= IndexW'(rd_entry_q);
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_data_q <= out_next;
    if (pal_rd_en) rd_entry_q <= issue_q[PalAw-1:0];
    if (accept) low_alpha_q <= (in_i.data.kind == KIND_ARGB) && (in_i.data.alpha <= AlphaLimit);
  end

  // palette store
  always_ff @(posedge clk_i) begin
    if (accept && in_i.data.kind == KIND_LOAD &&
        {1'b0, in_i.data.entry_number} < PalDepthW) begin
      pal_mem[in_i.data.entry_number[PalAw-1:0]] <=
        {in_i.data.blue, in_i.data.green, in_i.data.red};
    end
    if (pal_rd_en) pal_rdata_q <= pal_mem[issue_q[PalAw-1:0]];
  end

  // lookup table
  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_mem[color_q] <= best_entry_q;
    if (accept) tbl_rdata_q <= tbl_mem[pix_addr];
  end

endmodule
